### rtl/core/fopq_pkg.sv
`default_nettype none

package fopq_pkg;

    // take rules held in the mode register
    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_MAX  = 2'd1;
    localparam logic [1:0] MODE_MIN  = 2'd2;

    // operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    localparam int WORD_W = 32;
    localparam int HELD_W = 5;

    typedef logic signed [WORD_W-1:0] t_word;

    // one input transaction
    typedef struct packed {
        logic  opcode;
        t_word put_value;
    } t_in;

    // one result transaction
    typedef struct packed {
        logic              success;
        t_word             taken_value;
        logic [HELD_W-1:0] entries_held;
    } t_out;

endpackage

`default_nettype wire

### rtl/core/fopq_ram.sv
`default_nettype none

module fopq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/fopq_cmp.sv
`default_nettype none

module fopq_cmp (
    input  wire fopq_pkg::t_word i_cand,
    input  wire fopq_pkg::t_word i_cur,
    input  wire logic            i_max,
    output logic                 o_better
);

    // strict compare keeps the earliest of equal extremes
    always_comb begin
        if (i_max) begin
            o_better = (i_cand > i_cur);
        end else begin
            o_better = (i_cand < i_cur);
        end
    end

endmodule

`default_nettype wire

### rtl/core/fifo_or_priority_queue.sv
`default_nettype none
// Channel   Handshake                 Payload
// input     start, busy               i_item   (fopq_pkg::t_in)
// result    o_done                    o_result (fopq_pkg::t_out)
// config    i_cfg_we                  i_cfg_wdata (take mode)
//
// A put and any refused operation are answered from the idle state; the result shows the next cycle.
// A fifo take and a largest/smallest take each run one scan and one compaction
// pass, both paced by the single read and single write port of the entry RAM.
// Synchronous active-low reset clears the count, mode and sequencer.
// Results are strobed for one cycle; the receiver cannot stall them.

module fifo_or_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire fopq_pkg::t_in i_item,
    output logic               o_done,
    output fopq_pkg::t_out     o_result,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_wdata
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_mode;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;      // next address to read
    logic [CW-1:0]    r_len, n_len;      // scan length
    logic [IW-1:0]    r_sidx, n_sidx;    // index of data arriving from RAM
    logic [IW-1:0]    r_widx, n_widx;    // compaction write address
    logic             r_pend, n_pend;
    fopq_pkg::t_word  r_best, n_best;
    logic [IW-1:0]    r_at, n_at;
    logic             r_done, n_done;
    fopq_pkg::t_out   r_res, n_res;

    logic             ram_we, ram_re;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    fopq_pkg::t_word  ram_wdata, ram_q;
    logic             better, scan_mode, accept;

    fopq_ram #(
        .WIDTH(fopq_pkg::WORD_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    // shared compare unit for the extreme search
    fopq_cmp u_cmp (
        .i_cand  (ram_q),
        .i_cur   (r_best),
        .i_max   (r_mode == fopq_pkg::MODE_MAX),
        .o_better(better)
    );

    assign scan_mode = (r_mode == fopq_pkg::MODE_MAX) || (r_mode == fopq_pkg::MODE_MIN);
    assign accept    = start && (r_state == ST_IDLE);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_len     = r_len;
        n_sidx    = r_sidx;
        n_widx    = r_widx;
        n_pend    = 1'b0;
        n_best    = r_best;
        n_at      = r_at;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_widx;
        ram_wdata = ram_q;
        ram_re    = 1'b0;
        ram_raddr = r_idx[IW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res.taken_value = '0;
                    if (i_item.opcode == fopq_pkg::OP_PUT) begin
                        n_done = 1'b1;
                        if (r_count < CW'(CAPACITY)) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[IW-1:0];
                            ram_wdata = i_item.put_value;
                            n_count   = r_count + CW'(1);
                            n_res.success      = 1'b1;
                            n_res.entries_held = fopq_pkg::HELD_W'(r_count + CW'(1));
                        end else begin
                            n_res.success      = 1'b0;
                            n_res.entries_held = fopq_pkg::HELD_W'(r_count);
                        end
                    end else if (r_count == '0) begin
                        n_done             = 1'b1;
                        n_res.success      = 1'b0;
                        n_res.entries_held = '0;
                    end else begin
                        // first read of entry 0
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_idx     = CW'(1);
                        n_sidx    = '0;
                        n_len     = scan_mode ? r_count : CW'(1);
                        n_state   = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                if (r_idx < r_len) begin
                    ram_re = 1'b1;
                    n_idx  = r_idx + CW'(1);
                end
                if (r_sidx == '0 || better) begin
                    n_best = ram_q;
                    n_at   = r_sidx;
                end
                n_sidx = r_sidx + IW'(1);
                if (CW'(r_sidx) == r_len - CW'(1)) begin
                    // compaction starts behind the chosen entry
                    n_idx   = CW'(n_at) + CW'(1);
                    n_widx  = n_at;
                    n_state = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                if (r_pend) begin
                    ram_we = 1'b1;
                    n_widx = r_widx + IW'(1);
                end
                if (r_idx < r_count) begin
                    ram_re = 1'b1;
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_count            = r_count - CW'(1);
                    n_done             = 1'b1;
                    n_res.success      = 1'b1;
                    n_res.taken_value  = r_best;
                    n_res.entries_held = fopq_pkg::HELD_W'(r_count - CW'(1));
                    n_state            = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_mode  <= fopq_pkg::MODE_FIFO;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
        r_idx  <= n_idx;
        r_len  <= n_len;
        r_sidx <= n_sidx;
        r_widx <= n_widx;
        r_best <= n_best;
        r_at   <= n_at;
        r_res  <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

### rtl/core/fopq_chk.sv
`default_nettype none

module fopq_chk #(
    parameter int CAPACITY = 16
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire fopq_pkg::t_in  i_item,
    input wire logic           o_done,
    input wire fopq_pkg::t_out o_result
);

    // a put transaction answers on the next cycle with no value
    a_put_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.opcode == fopq_pkg::OP_PUT)
        |=> o_done && !busy && (o_result.taken_value == '0))
        else $error("put transaction did not answer next cycle");

    // the end of a take leaves a result
    a_take_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_done)
        else $error("take finished without result");

    // failed operations return zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.success |-> (o_result.taken_value == '0))
        else $error("failed transaction returned a value");

    // entry count stays within capacity, checked only when CAPACITY is below 32
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (CAPACITY >= 32) || (int'(o_result.entries_held) <= CAPACITY))
        else $error("entry count above capacity");

endmodule

bind fifo_or_priority_queue fopq_chk #(.CAPACITY(CAPACITY)) u_fopq_chk (.*);

`default_nettype wire
